FILE: rtl/core/sk_pkg.sv
// shared types and constants of the spectral kurtosis detector
// no dependencies
package sk_pkg;

   localparam int CFG_BLOCK_W = 11;
   localparam int CFG_CHANS_W = 11;
   localparam int CFG_POLS_W  = 2;
   localparam int THRESH_W    = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int SK_W        = 32;
   localparam int FRAC_BITS   = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_CHANS = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NUM_POLS  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_LOWER     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_UPPER     = 3'd4;

   localparam logic [CFG_BLOCK_W-1:0] BLOCK_LEN_RESET = 11'd128;
   localparam logic [CFG_CHANS_W-1:0] NUM_CHANS_RESET = 11'd1024;
   localparam logic [CFG_POLS_W-1:0]  NUM_POLS_RESET  = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_READ,
      ST_UPDATE,
      ST_CALC,
      ST_HOLD
   } ctrl_state_type;

   typedef enum logic [2:0] {
      D_IDLE,
      D_SQ,
      D_DIFF,
      D_NUM,
      D_PREP,
      D_DIV,
      D_DONE
   } div_state_type;

endpackage

FILE: rtl/core/sk_if.sv
// handshake channels of the spectral kurtosis detector
// depends on sk_pkg
interface sk_req_if #(parameter int SAMPLE_W = 8);
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] re;
   logic signed [SAMPLE_W-1:0] im;
   modport source (output valid, re, im, input ready);
   modport sink   (input valid, re, im, output ready);
endinterface

interface sk_rsp_if #(parameter int CHAN_W = 10);
   logic                        valid;
   logic                        ready;
   logic [CHAN_W-1:0]           chan_index;
   logic                        pol_index;
   logic [sk_pkg::SK_W-1:0]     sk_value;
   logic                        out_of_range;
   logic                        channel_zap;
   logic                        last;
   modport source (output valid, chan_index, pol_index, sk_value, out_of_range,
                   channel_zap, last, input ready);
   modport sink   (input valid, chan_index, pol_index, sk_value, out_of_range,
                   channel_zap, last, output ready);
endinterface

interface sk_csr_if;
   logic                          valid;
   logic                          ready;
   logic [sk_pkg::CSR_IDX_W-1:0]  index;
   logic [sk_pkg::CSR_DATA_W-1:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/sk_acc_mem.sv
// accumulator store for power and squared-power sums, one entry per channel/pol
// registered read, one write port; no dependencies
module sk_acc_mem #(
   parameter int ADDR_W = 11,
   parameter int S1W    = 26,
   parameter int S2W    = 41
) (
   input  logic              clock,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [S1W-1:0]    rd_s1,
   output logic [S2W-1:0]    rd_s2,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [S1W-1:0]    wr_s1,
   input  logic [S2W-1:0]    wr_s2
);

   logic [S1W-1:0] s1_mem [2**ADDR_W];
   logic [S2W-1:0] s2_mem [2**ADDR_W];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         s1_mem[wr_addr] <= wr_s1;
         s2_mem[wr_addr] <= wr_s2;
      end
   end

   always_ff @(posedge clock) begin
      rd_s1 <= s1_mem[rd_addr];
      rd_s2 <= s2_mem[rd_addr];
   end

endmodule

FILE: rtl/core/sk_div.sv
// kurtosis estimate unit: staged products then a radix-2 restoring divide
// depends on sk_pkg
module sk_div #(
   parameter int MW  = 11,
   parameter int S1W = 26,
   parameter int S2W = 41
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [MW-1:0]           m,
   input  logic [S1W-1:0]          s1,
   input  logic [S2W-1:0]          s2,
   output logic                    done,
   output logic [sk_pkg::SK_W-1:0] q
);

   localparam int SQW   = 2 * S1W;
   localparam int MS2W  = S2W + MW;
   localparam int NUMW  = MS2W + MW + sk_pkg::FRAC_BITS;
   localparam int DENW  = SQW + MW;
   localparam int QW    = sk_pkg::SK_W;
   localparam int HIW   = NUMW - QW;
   localparam int CMPW  = (HIW > DENW) ? HIW : DENW;
   localparam int CNTW  = $clog2(QW);

   sk_pkg::div_state_type state_ff, state_in;

   logic [MW-1:0]   m_ff;
   logic [S1W-1:0]  s1_ff;
   logic [S2W-1:0]  s2_ff;
   logic [SQW-1:0]  s1sq_ff;
   logic [MS2W-1:0] ms2_ff;
   logic [MS2W-1:0] diff_ff;
   logic [DENW-1:0] den_ff;
   logic            zero_ff;
   logic [NUMW-1:0] num_ff;
   logic [DENW-1:0] rem_ff;
   logic [QW-1:0]   numlo_ff;
   logic [QW-1:0]   q_ff;
   logic [CNTW-1:0] cnt_ff;

   logic [DENW:0]   rem_sh;
   logic            rem_ge;
   logic [HIW-1:0]  num_hi;

   assign num_hi = num_ff[NUMW-1:QW];
   assign rem_sh = {rem_ff, numlo_ff[QW-1]};
   assign rem_ge = rem_sh >= {1'b0, den_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sk_pkg::D_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sk_pkg::D_IDLE: if (start) state_in = sk_pkg::D_SQ;
         sk_pkg::D_SQ:   state_in = sk_pkg::D_DIFF;
         sk_pkg::D_DIFF: state_in = sk_pkg::D_NUM;
         sk_pkg::D_NUM:  state_in = sk_pkg::D_PREP;
         sk_pkg::D_PREP: begin
            if (zero_ff || CMPW'(num_hi) >= CMPW'(den_ff)) begin
               state_in = sk_pkg::D_DONE;
            end else begin
               state_in = sk_pkg::D_DIV;
            end
         end
         sk_pkg::D_DIV:  if (cnt_ff == CNTW'(QW - 1)) state_in = sk_pkg::D_DONE;
         sk_pkg::D_DONE: state_in = sk_pkg::D_IDLE;
         default:        state_in = sk_pkg::D_IDLE;
      endcase
   end

   always_comb begin
      done = (state_ff == sk_pkg::D_DONE);
   end

   assign q = q_ff;

   always_ff @(posedge clock) begin
      case (state_ff)
         sk_pkg::D_IDLE: begin
            m_ff  <= m;
            s1_ff <= s1;
            s2_ff <= s2;
         end
         sk_pkg::D_SQ: begin
            s1sq_ff <= s1_ff * s1_ff;
            ms2_ff  <= MS2W'(m_ff * s2_ff);
         end
         sk_pkg::D_DIFF: begin
            zero_ff <= (s1_ff == '0) || (MS2W'(s1sq_ff) >= ms2_ff) ||
                       (SQW > MS2W && (s1sq_ff >> MS2W) != '0);
            diff_ff <= ms2_ff - MS2W'(s1sq_ff);
            den_ff  <= DENW'(s1sq_ff * (m_ff - MW'(1)));
         end
         sk_pkg::D_NUM: begin
            num_ff <= {(MS2W + MW)'(diff_ff * (m_ff + MW'(1))),
                       {sk_pkg::FRAC_BITS{1'b0}}};
         end
         sk_pkg::D_PREP: begin
            cnt_ff   <= '0;
            rem_ff   <= DENW'(num_hi);
            numlo_ff <= num_ff[QW-1:0];
            if (zero_ff) begin
               q_ff <= '0;
            end else begin
               q_ff <= '1;
            end
         end
         sk_pkg::D_DIV: begin
            cnt_ff   <= cnt_ff + CNTW'(1);
            numlo_ff <= {numlo_ff[QW-2:0], 1'b0};
            q_ff     <= {q_ff[QW-2:0], rem_ge};
            if (rem_ge) begin
               rem_ff <= DENW'(rem_sh - {1'b0, den_ff});
            end else begin
               rem_ff <= DENW'(rem_sh);
            end
         end
         default: begin
         end
      endcase
   end

endmodule

FILE: rtl/core/spectral_kurtosis_rfi_detector.sv
// Spectral kurtosis RFI detector. Complex samples arrive in time, channel,
// polarization order; each beat passes through accept, memory read, then
// read-modify-write of the running sums. On the last time sample of a block
// the estimate unit then runs its product steps, a setup step and, unless the
// result is zero or saturates, a restoring divide before the result beat is
// registered. The sums sit in 2**(CW+1) memory entries, CW = clog2(MAX_CHANS), min 1.
// depends on sk_pkg, sk_if, sk_acc_mem, sk_div
module spectral_kurtosis_rfi_detector #(
   parameter int MAX_CHANS   = 1024,
   parameter int MAX_BLOCK   = 1024,
   parameter int SAMPLE_BITS = 8
) (
   input logic     clock,
   input logic     reset,
   sk_req_if.sink  req,
   sk_rsp_if.source rsp,
   sk_csr_if.sink  csr
);

   localparam int CW   = (MAX_CHANS > 1) ? $clog2(MAX_CHANS) : 1;
   localparam int TW   = $clog2(MAX_BLOCK);
   localparam int AW   = CW + 1;
   localparam int PW   = 2 * SAMPLE_BITS;
   localparam int S1W  = PW + TW;
   localparam int S2W  = 2 * PW - 1 + TW;
   localparam int MW   = $clog2(MAX_BLOCK + 2);
   localparam int LW   = (MW > sk_pkg::CFG_BLOCK_W) ? MW : sk_pkg::CFG_BLOCK_W;
   localparam int NLW  = (CW + 1 > sk_pkg::CFG_CHANS_W) ? CW + 1 : sk_pkg::CFG_CHANS_W;

   sk_pkg::ctrl_state_type state_ff, state_in;

   logic [sk_pkg::CFG_BLOCK_W-1:0] block_len_ff;
   logic [sk_pkg::CFG_CHANS_W-1:0] num_chans_ff;
   logic [sk_pkg::CFG_POLS_W-1:0]  num_pols_ff;
   logic [sk_pkg::THRESH_W-1:0]    lower_ff;
   logic [sk_pkg::THRESH_W-1:0]    upper_ff;

   logic [TW-1:0] time_ff;
   logic [CW-1:0] chan_ff;
   logic          pol_ff;
   logic          flag_acc_ff;

   logic [LW-1:0]  m_sel;
   logic [NLW-1:0] nc_sel;
   logic           time_last, chan_last, pol_last;
   logic           accept;

   logic signed [PW-1:0] re_sq, im_sq;
   logic [PW-1:0]        power;

   logic [PW-1:0]  power_ff;
   logic [AW-1:0]  addr_ff;
   logic           first_ff, time_last_ff, chan_last_ff, pol_last_ff;
   logic [CW-1:0]  chan_cap_ff;
   logic           pol_cap_ff;
   logic [MW-1:0]  m_ff;

   logic [AW-1:0]  rd_addr;
   logic [S1W-1:0] rd_s1, new_s1;
   logic [S2W-1:0] rd_s2, new_s2;
   logic [S2W-1:0] psq;
   logic           mem_wr;
   logic           div_start, div_done;
   logic [sk_pkg::SK_W-1:0] div_q;
   logic           flag;
   logic           out_free;
   logic           out_load;

   logic                    rsp_valid_ff;
   logic [CW-1:0]           rsp_chan_ff;
   logic                    rsp_pol_ff;
   logic [sk_pkg::SK_W-1:0] rsp_sk_ff;
   logic                    rsp_oor_ff, rsp_zap_ff, rsp_last_ff;

   // config port
   assign csr.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff <= sk_pkg::BLOCK_LEN_RESET;
         num_chans_ff <= sk_pkg::NUM_CHANS_RESET;
         num_pols_ff  <= sk_pkg::NUM_POLS_RESET;
         lower_ff     <= '0;
         upper_ff     <= '1;
      end else if (csr.valid) begin
         unique case (csr.index)
            sk_pkg::CSR_BLOCK_LEN: block_len_ff <= csr.data[sk_pkg::CFG_BLOCK_W-1:0];
            sk_pkg::CSR_NUM_CHANS: num_chans_ff <= csr.data[sk_pkg::CFG_CHANS_W-1:0];
            sk_pkg::CSR_NUM_POLS:  num_pols_ff  <= csr.data[sk_pkg::CFG_POLS_W-1:0];
            sk_pkg::CSR_LOWER:     lower_ff     <= csr.data;
            sk_pkg::CSR_UPPER:     upper_ff     <= csr.data;
            default: begin
            end
         endcase
      end
   end

   // clamped limits
   always_comb begin
      m_sel = LW'(block_len_ff);
      if (m_sel < LW'(2)) begin
         m_sel = LW'(2);
      end else if (m_sel > LW'(MAX_BLOCK)) begin
         m_sel = LW'(MAX_BLOCK);
      end
      nc_sel = NLW'(num_chans_ff);
      if (nc_sel < NLW'(1)) begin
         nc_sel = NLW'(1);
      end else if (nc_sel > NLW'(MAX_CHANS)) begin
         nc_sel = NLW'(MAX_CHANS);
      end
   end

   assign time_last = LW'(time_ff) >= m_sel - LW'(1);
   assign chan_last = NLW'(chan_ff) >= nc_sel - NLW'(1);
   assign pol_last  = (num_pols_ff >= 2'd2) ? pol_ff : 1'b1;

   assign req.ready = (state_ff == sk_pkg::ST_IDLE);
   assign accept    = req.valid && req.ready;

   assign re_sq = req.re * req.re;
   assign im_sq = req.im * req.im;
   assign power = $unsigned(re_sq) + $unsigned(im_sq);

   // stream position counters
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         chan_ff <= '0;
         pol_ff  <= 1'b0;
      end else if (accept) begin
         if (pol_last) begin
            pol_ff <= 1'b0;
            if (chan_last) begin
               chan_ff <= '0;
               time_ff <= time_last ? '0 : time_ff + TW'(1);
            end else begin
               chan_ff <= chan_ff + CW'(1);
            end
         end else begin
            pol_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         power_ff     <= power;
         addr_ff      <= {chan_ff, pol_ff};
         first_ff     <= (time_ff == '0);
         time_last_ff <= time_last;
         chan_last_ff <= chan_last;
         pol_last_ff  <= pol_last;
         chan_cap_ff  <= chan_ff;
         pol_cap_ff   <= pol_ff;
         m_ff         <= MW'(m_sel);
      end
   end

   // sum update
   assign rd_addr = (state_ff == sk_pkg::ST_IDLE) ? {chan_ff, pol_ff} : addr_ff;
   assign psq    = S2W'(power_ff * power_ff);
   assign new_s1 = first_ff ? S1W'(power_ff) : rd_s1 + S1W'(power_ff);
   assign new_s2 = first_ff ? psq : rd_s2 + psq;

   sk_acc_mem #(
      .ADDR_W (AW),
      .S1W    (S1W),
      .S2W    (S2W)
   ) u_mem (
      .clock   (clock),
      .rd_addr (rd_addr),
      .rd_s1   (rd_s1),
      .rd_s2   (rd_s2),
      .wr_en   (mem_wr),
      .wr_addr (addr_ff),
      .wr_s1   (new_s1),
      .wr_s2   (new_s2)
   );

   sk_div #(
      .MW  (MW),
      .S1W (S1W),
      .S2W (S2W)
   ) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .m     (m_ff),
      .s1    (new_s1),
      .s2    (new_s2),
      .done  (div_done),
      .q     (div_q)
   );

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sk_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sk_pkg::ST_IDLE:   if (accept) state_in = sk_pkg::ST_READ;
         sk_pkg::ST_READ:   state_in = sk_pkg::ST_UPDATE;
         sk_pkg::ST_UPDATE: state_in = time_last_ff ? sk_pkg::ST_CALC : sk_pkg::ST_IDLE;
         sk_pkg::ST_CALC:   if (div_done) state_in = sk_pkg::ST_HOLD;
         sk_pkg::ST_HOLD:   if (out_free) state_in = sk_pkg::ST_IDLE;
         default:           state_in = sk_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      mem_wr    = (state_ff == sk_pkg::ST_UPDATE);
      div_start = (state_ff == sk_pkg::ST_UPDATE) && time_last_ff;
      out_load  = (state_ff == sk_pkg::ST_HOLD) && out_free;
   end

   // result beat
   logic [sk_pkg::SK_W-1:0] sk_hold_ff;

   always_ff @(posedge clock) begin
      if (div_done) begin
         sk_hold_ff <= div_q;
      end
   end

   assign flag = (sk_hold_ff > upper_ff) || (sk_hold_ff < lower_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         flag_acc_ff  <= 1'b0;
      end else begin
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            flag_acc_ff  <= pol_last_ff ? 1'b0 : (flag_acc_ff | flag);
         end else if (rsp.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_chan_ff <= chan_cap_ff;
         rsp_pol_ff  <= pol_cap_ff;
         rsp_sk_ff   <= sk_hold_ff;
         rsp_oor_ff  <= flag;
         rsp_zap_ff  <= pol_last_ff && (flag_acc_ff | flag);
         rsp_last_ff <= pol_last_ff && chan_last_ff;
      end
   end

   assign rsp.valid        = rsp_valid_ff;
   assign rsp.chan_index   = rsp_chan_ff;
   assign rsp.pol_index    = rsp_pol_ff;
   assign rsp.sk_value     = rsp_sk_ff;
   assign rsp.out_of_range = rsp_oor_ff;
   assign rsp.channel_zap  = rsp_zap_ff;
   assign rsp.last         = rsp_last_ff;

   a_accept_reads: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == sk_pkg::ST_READ)
      else $error("accepted beat did not start a memory read");

   a_plain_beat: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sk_pkg::ST_UPDATE && !time_last_ff) |=> state_ff == sk_pkg::ST_IDLE)
      else $error("beat without block end did not return to idle");

   a_result_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == sk_pkg::ST_HOLD)
      else $error("result beat raised outside hold state");

   a_zap_last_pol: assert property (@(posedge clock) disable iff (reset)
      out_load && !pol_last_ff |=> !rsp_zap_ff)
      else $error("channel zap raised before the last polarisation");

endmodule
